@@ rtl/core/psd_pkg.sv @@
`default_nettype none
package psd_pkg;

	// field widths
	localparam int COORD_BITS     = 24;
	localparam int QUOT_FRAC_BITS = 16;
	localparam int DIST_BITS      = 50;

	// derived datapath widths
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int DOT_W  = PROD_W + 2;
	localparam int DEN_W  = PROD_W;
	localparam int R_W    = DEN_W + 1;
	localparam int T_W    = QUOT_FRAC_BITS + 1;
	localparam int PM_W   = DIFF_W + T_W;
	localparam int PN_W   = DIFF_W;
	localparam int PROJ_W = DIFF_W + 1;
	localparam int RV_W   = DIFF_W + 2;
	localparam int SQ_W   = 2 * RV_W;
	localparam int SUM_W  = SQ_W + 2;

	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	// configuration register indexes
	localparam int CFG_IDX_W    = 3;
	localparam int NUM_SEG_REGS = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_END_Z   = 3'd5;

	typedef enum logic [1:0] {
		REGION_INTERIOR = 2'd0,
		REGION_START    = 2'd1,
		REGION_END      = 2'd2
	} region_t;

	// data that rides along the divider stages
	typedef struct packed {
		region_t                     region;
		logic [DIST_BITS-1:0]        dist_val;
		logic signed [DIFF_W-1:0]    cx;
		logic signed [DIFF_W-1:0]    cy;
		logic signed [DIFF_W-1:0]    cz;
	} side_t;

endpackage
`default_nettype wire

@@ rtl/core/psd_div.sv @@
`default_nettype none
// restoring divider, one quotient bit per stage, num <= den assumed
module psd_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_vld,
	input  wire logic [psd_pkg::DEN_W-1:0]     in_num,
	input  wire logic [psd_pkg::DEN_W-1:0]     in_den,
	input  wire psd_pkg::side_t                in_side,
	output logic                               out_vld,
	output logic [psd_pkg::T_W-1:0]            out_quo,
	output psd_pkg::side_t                     out_side
);

	localparam int NST = psd_pkg::T_W;

	logic [NST-1:0]               vld_s;
	logic [psd_pkg::R_W-1:0]      rem_s  [NST];
	logic [psd_pkg::T_W-1:0]      quo_s  [NST];
	logic [psd_pkg::DEN_W-1:0]    den_s  [NST];
	psd_pkg::side_t               side_s [NST];

	for (genvar k = 0; k < NST; k++) begin : g_stage
		logic [psd_pkg::R_W-1:0]   r_in;
		logic [psd_pkg::T_W-1:0]   q_in;
		logic [psd_pkg::DEN_W-1:0] d_in;
		psd_pkg::side_t            s_in;
		logic                      v_in;
		logic                      ge;

		// stage inputs: first stage takes the operands, later ones shift the remainder
		if (k == 0) begin : g_first
			assign r_in = psd_pkg::R_W'(in_num);
			assign q_in = '0;
			assign d_in = in_den;
			assign s_in = in_side;
			assign v_in = in_vld;
		end else begin : g_next
			assign r_in = {rem_s[k-1][psd_pkg::R_W-2:0], 1'b0};
			assign q_in = quo_s[k-1];
			assign d_in = den_s[k-1];
			assign s_in = side_s[k-1];
			assign v_in = vld_s[k-1];
		end

		assign ge = (r_in >= psd_pkg::R_W'(d_in));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		// trial subtract
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? (r_in - psd_pkg::R_W'(d_in)) : r_in;
				quo_s[k]  <= {q_in[psd_pkg::T_W-2:0], ge};
				den_s[k]  <= d_in;
				side_s[k] <= s_in;
			end
		end
	end

	assign out_vld  = vld_s[NST-1];
	assign out_quo  = quo_s[NST-1];
	assign out_side = side_s[NST-1];

endmodule
`default_nettype wire

@@ rtl/core/point_segment_distance_squared.sv @@
`default_nettype none
// squared distance from a streamed 3-d query point to a configured segment
// cfg channel: cfg_valid/cfg_ready with cfg_index (0..5: start x,y,z, end x,y,z)
//   and cfg_data; cfg_ready is always high, indexes above 5 are dropped.
//   write only while no beat is in flight.
// input channel: in_valid/in_ready with point_x/y/z, signed q16.8
// output channel: out_valid/out_ready with dist_sq (units of 2^-16) and region
//   (0 interior, 1 start, 2 end)
// fully pipelined: one beat per cycle while the output is not stalled; 3 front
//   stages (differences, products, dot sums), 17 divider stages (one quotient
//   bit each), 4 back stages (projection, difference, square, sum and clamp
//   into the output register)
// a stalled receiver freezes the whole pipeline; in_ready is low while the
//   output register holds an untaken beat
// reset clears the segment registers to zero and empties the pipeline
module point_segment_distance_squared (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [psd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [psd_pkg::COORD_BITS-1:0]        cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [psd_pkg::COORD_BITS-1:0] point_x,
	input  wire logic signed [psd_pkg::COORD_BITS-1:0] point_y,
	input  wire logic signed [psd_pkg::COORD_BITS-1:0] point_z,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [psd_pkg::DIST_BITS-1:0]              dist_sq,
	output logic [1:0]                                 region
);

	localparam int DW = psd_pkg::DIFF_W;
	localparam int QF = psd_pkg::QUOT_FRAC_BITS;

	logic signed [psd_pkg::COORD_BITS-1:0] seg_q [psd_pkg::NUM_SEG_REGS];
	logic                                  en;

	// segment registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < psd_pkg::NUM_SEG_REGS; i++) seg_q[i] <= '0;
		end else if (cfg_valid) begin
			for (int i = 0; i < psd_pkg::NUM_SEG_REGS; i++) begin
				if (cfg_index == psd_pkg::CFG_IDX_W'(i)) seg_q[i] <= cfg_data;
			end
		end
	end

	// segment direction; the user must keep it static while beats are in flight, which the block itself does not enforce
	logic signed [DW-1:0] av [3];
	assign av[0] = DW'(seg_q[psd_pkg::CFG_END_X]) - DW'(seg_q[psd_pkg::CFG_START_X]);
	assign av[1] = DW'(seg_q[psd_pkg::CFG_END_Y]) - DW'(seg_q[psd_pkg::CFG_START_Y]);
	assign av[2] = DW'(seg_q[psd_pkg::CFG_END_Z]) - DW'(seg_q[psd_pkg::CFG_START_Z]);

	// global advance: output register empty or being taken
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: point minus start and point minus end
	logic                 vld_s1;
	logic signed [DW-1:0] cv_s1 [3];
	logic signed [DW-1:0] dv_s1 [3];
	logic signed [psd_pkg::COORD_BITS-1:0] pt [3];
	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				cv_s1[i] <= DW'(pt[i]) - DW'(seg_q[i]);
				dv_s1[i] <= DW'(pt[i]) - DW'(seg_q[3 + i]);
			end
		end
	end

	// stage 2: component products
	logic                                vld_s2;
	logic signed [psd_pkg::PROD_W-1:0]   pac_s2 [3];
	logic signed [psd_pkg::PROD_W-1:0]   paa_s2 [3];
	logic signed [psd_pkg::PROD_W-1:0]   pcc_s2 [3];
	logic signed [psd_pkg::PROD_W-1:0]   pdd_s2 [3];
	logic signed [DW-1:0]                cv_s2  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pac_s2[i] <= av[i] * cv_s1[i];
				paa_s2[i] <= av[i] * av[i];
				pcc_s2[i] <= cv_s1[i] * cv_s1[i];
				pdd_s2[i] <= dv_s1[i] * dv_s1[i];
				cv_s2[i]  <= cv_s1[i];
			end
		end
	end

	// stage 3: dot products and region decision
	localparam int DTW = psd_pkg::DOT_W;
	logic signed [DTW-1:0] num_c, den_c, csum_c, dsum_c;
	logic [psd_pkg::DIST_BITS-1:0] cdist_c, ddist_c;
	psd_pkg::side_t side_c, side_s3;
	logic [psd_pkg::DEN_W-1:0] num_s3, den_s3;
	logic vld_s3;

	assign num_c  = DTW'(pac_s2[0]) + DTW'(pac_s2[1]) + DTW'(pac_s2[2]);
	assign den_c  = DTW'(paa_s2[0]) + DTW'(paa_s2[1]) + DTW'(paa_s2[2]);
	assign csum_c = DTW'(pcc_s2[0]) + DTW'(pcc_s2[1]) + DTW'(pcc_s2[2]);
	assign dsum_c = DTW'(pdd_s2[0]) + DTW'(pdd_s2[1]) + DTW'(pdd_s2[2]);
	assign cdist_c = (csum_c > DTW'(psd_pkg::DIST_MAX)) ? psd_pkg::DIST_MAX
		: csum_c[psd_pkg::DIST_BITS-1:0];
	assign ddist_c = (dsum_c > DTW'(psd_pkg::DIST_MAX)) ? psd_pkg::DIST_MAX
		: dsum_c[psd_pkg::DIST_BITS-1:0];

	always_comb begin
		side_c.cx = cv_s2[0];
		side_c.cy = cv_s2[1];
		side_c.cz = cv_s2[2];
		priority if (num_c < 0) begin
			side_c.region   = psd_pkg::REGION_START;
			side_c.dist_val = cdist_c;
		end else if (num_c > den_c) begin
			side_c.region   = psd_pkg::REGION_END;
			side_c.dist_val = ddist_c;
		end else if (den_c == '0) begin
			side_c.region   = psd_pkg::REGION_START;
			side_c.dist_val = cdist_c;
		end else begin
			side_c.region   = psd_pkg::REGION_INTERIOR;
			side_c.dist_val = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_c;
			num_s3  <= num_c[psd_pkg::DEN_W-1:0];
			den_s3  <= den_c[psd_pkg::DEN_W-1:0];
		end
	end

	// projection parameter t = num / den
	logic                      vld_dv;
	logic [psd_pkg::T_W-1:0]   t_dv;
	psd_pkg::side_t            side_dv;

	psd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.in_num   (num_s3),
		.in_den   (den_s3),
		.in_side  (side_s3),
		.out_vld  (vld_dv),
		.out_quo  (t_dv),
		.out_side (side_dv)
	);

	// stage 4: |a| * t
	logic                         vld_s4;
	logic [psd_pkg::PM_W-1:0]     pm_s4  [3];
	logic [2:0]                   aneg_s4;
	psd_pkg::side_t               side_s4;
	logic [DW-1:0]                amag   [3];

	for (genvar i = 0; i < 3; i++) begin : g_amag
		assign amag[i] = av[i][DW-1] ? DW'(-av[i]) : DW'(av[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_dv;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pm_s4[i]   <= psd_pkg::PM_W'(amag[i]) * psd_pkg::PM_W'(t_dv);
				aneg_s4[i] <= av[i][DW-1];
			end
			side_s4 <= side_dv;
		end
	end

	// stage 5: floor of projection, residual magnitude
	logic                          vld_s5;
	logic [psd_pkg::RV_W-1:0]      rmag_s5 [3];
	psd_pkg::side_t                side_s5;
	logic [psd_pkg::PM_W:0]        pm_up   [3];
	logic [psd_pkg::PN_W-1:0]      pn      [3];
	logic signed [psd_pkg::PROJ_W-1:0] proj [3];
	logic signed [psd_pkg::RV_W-1:0]   rv   [3];
	logic signed [DW-1:0]              cs4  [3];

	assign cs4[0] = side_s4.cx;
	assign cs4[1] = side_s4.cy;
	assign cs4[2] = side_s4.cz;

	for (genvar i = 0; i < 3; i++) begin : g_proj
		assign pm_up[i] = (psd_pkg::PM_W + 1)'(pm_s4[i])
			+ (aneg_s4[i] ? (psd_pkg::PM_W + 1)'((1 << QF) - 1) : '0);
		assign pn[i]    = psd_pkg::PN_W'(pm_up[i] >> QF);
		assign proj[i]  = aneg_s4[i] ? -$signed(psd_pkg::PROJ_W'(pn[i]))
			: $signed(psd_pkg::PROJ_W'(pn[i]));
		assign rv[i]    = psd_pkg::RV_W'(cs4[i]) - psd_pkg::RV_W'(proj[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rmag_s5[i] <= rv[i][psd_pkg::RV_W-1] ? psd_pkg::RV_W'(-rv[i])
					: psd_pkg::RV_W'(rv[i]);
			end
			side_s5 <= side_s4;
		end
	end

	// stage 6: squares
	logic                       vld_s6;
	logic [psd_pkg::SQ_W-1:0]   sq_s6 [3];
	psd_pkg::side_t             side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (en) vld_s6 <= vld_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= psd_pkg::SQ_W'(rmag_s5[i]) * psd_pkg::SQ_W'(rmag_s5[i]);
			end
			side_s6 <= side_s5;
		end
	end

	// stage 7: sum, clamp, select, output register
	logic                            vld_s7;
	logic [psd_pkg::DIST_BITS-1:0]   dist_s7;
	psd_pkg::region_t                region_s7;
	logic [psd_pkg::SUM_W-1:0]       rsum;
	logic [psd_pkg::DIST_BITS-1:0]   rdist;

	assign rsum  = psd_pkg::SUM_W'(sq_s6[0]) + psd_pkg::SUM_W'(sq_s6[1])
		+ psd_pkg::SUM_W'(sq_s6[2]);
	assign rdist = (rsum > psd_pkg::SUM_W'(psd_pkg::DIST_MAX)) ? psd_pkg::DIST_MAX
		: rsum[psd_pkg::DIST_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (en) vld_s7 <= vld_s6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			region_s7 <= side_s6.region;
			dist_s7   <= (side_s6.region == psd_pkg::REGION_INTERIOR) ? rdist
				: side_s6.dist_val;
		end
	end

	assign out_valid = vld_s7;
	assign dist_sq   = dist_s7;
	assign region    = region_s7;

endmodule
`default_nettype wire

@@ rtl/core/psd_check.sv @@
`default_nettype none
// port-level checks on the distance block
module psd_check (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  cfg_ready,
	input wire logic                                  in_ready,
	input wire logic                                  out_valid,
	input wire logic                                  out_ready,
	input wire logic [psd_pkg::DIST_BITS-1:0]         dist_sq,
	input wire logic [1:0]                            region
);

	// input side opens exactly when the output register can move
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output stall");

	// delivered region is a legal code
	a_region_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (region == psd_pkg::REGION_INTERIOR
			|| region == psd_pkg::REGION_START || region == psd_pkg::REGION_END))
		else $error("illegal region code");

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dist_sq) && $stable(region))
		else $error("output beat changed under stall");

	// config is always accepted
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("cfg_ready dropped");

endmodule

bind point_segment_distance_squared psd_check u_psd_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg_ready),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.dist_sq   (dist_sq),
	.region    (region)
);
`default_nettype wire

@@ dv/point_segment_distance_squared_tb.sv @@
module point_segment_distance_squared_tb;
	import psd_pkg::*;

	localparam longint CYCLE_LIMIT = 2000000;
	localparam int     DRAIN_WAIT  = 40;
	localparam int     HOLD_CYCLES = 300;
	localparam int     RANDOM_PER_PHASE = 205;

	typedef struct {
		logic [DIST_BITS-1:0] dist_val;
		region_t              reg_id;
	} dist_result_t;

	// predicts squared distance per beat and checks results in order
	class dist_scoreboard;
		logic signed [COORD_BITS-1:0] seg[6];
		dist_result_t pending_q[$];
		int mismatches;
		int beats_checked;
		int region_hits[3];

		function new();
			for (int i = 0; i < 6; i++) seg[i] = '0;
			mismatches = 0;
			beats_checked = 0;
			for (int i = 0; i < 3; i++) region_hits[i] = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_BITS-1:0] val);
			if (idx < NUM_SEG_REGS) seg[idx] = val;
		endfunction

		// sum of squares of three deltas, clamped to the output width
		function logic [DIST_BITS-1:0] sum_sq(longint v0, longint v1, longint v2);
			longint vals[3];
			longint m;
			longint acc;
			vals[0] = v0; vals[1] = v1; vals[2] = v2;
			acc = 0;
			for (int i = 0; i < 3; i++) begin
				m = (vals[i] < 0) ? -vals[i] : vals[i];
				if (m >= (longint'(1) << (DIST_BITS / 2))) return DIST_MAX;
				acc += m * m;
			end
			if (acc > longint'(DIST_MAX)) return DIST_MAX;
			return acc[DIST_BITS-1:0];
		endfunction

		function void note_point(logic signed [COORD_BITS-1:0] px,
				logic signed [COORD_BITS-1:0] py, logic signed [COORD_BITS-1:0] pz);
			longint a[3], c[3], d[3], p[3];
			longint num, ed, den, t;
			logic [127:0] quot;
			dist_result_t res;
			p[0] = px; p[1] = py; p[2] = pz;
			for (int i = 0; i < 3; i++) begin
				a[i] = longint'(seg[3+i]) - longint'(seg[i]);
				c[i] = p[i] - longint'(seg[i]);
				d[i] = p[i] - longint'(seg[3+i]);
			end
			num = a[0]*c[0] + a[1]*c[1] + a[2]*c[2];
			ed  = a[0]*d[0] + a[1]*d[1] + a[2]*d[2];
			den = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
			if (num < 0) begin
				res.reg_id = REGION_START;
				res.dist_val = sum_sq(c[0], c[1], c[2]);
			end else if (ed > 0) begin
				res.reg_id = REGION_END;
				res.dist_val = sum_sq(d[0], d[1], d[2]);
			end else if (den == 0) begin
				// degenerate segment falls back to the start point
				res.reg_id = REGION_START;
				res.dist_val = sum_sq(c[0], c[1], c[2]);
			end else begin
				quot = (128'(num) << QUOT_FRAC_BITS) / 128'(den);
				t = longint'(quot);
				res.reg_id = REGION_INTERIOR;
				res.dist_val = sum_sq(c[0] - ((a[0]*t) >>> QUOT_FRAC_BITS),
					c[1] - ((a[1]*t) >>> QUOT_FRAC_BITS),
					c[2] - ((a[2]*t) >>> QUOT_FRAC_BITS));
			end
			pending_q.push_back(res);
		endfunction

		function void check_result(logic [DIST_BITS-1:0] got_dist, logic [1:0] reg_id);
			dist_result_t want;
			beats_checked++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: dist_sq %0d region %0d", got_dist, reg_id);
				return;
			end
			want = pending_q.pop_front();
			if (want.reg_id <= REGION_END) region_hits[want.reg_id]++;
			if (got_dist !== want.dist_val || reg_id !== 2'(want.reg_id)) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch beat %0d: dist_sq exp %0d got %0d, region exp %0d got %0d",
						beats_checked, want.dist_val, got_dist, want.reg_id, reg_id);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [COORD_BITS-1:0] point_x = '0;
	logic signed [COORD_BITS-1:0] point_y = '0;
	logic signed [COORD_BITS-1:0] point_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DIST_BITS-1:0] dist_sq;
	logic [1:0] region;

	dist_scoreboard sb = new();
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	longint cycles = 0;
	int segments_used = 0;

	point_segment_distance_squared dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.dist_sq(dist_sq), .region(region)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: check each taken beat, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(dist_sq, region);
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// write all six segment registers plus the two unused indexes
	task automatic write_segment(logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy,
			logic [COORD_BITS-1:0] sz, logic [COORD_BITS-1:0] ex,
			logic [COORD_BITS-1:0] ey, logic [COORD_BITS-1:0] ez);
		logic [COORD_BITS-1:0] vals[8];
		vals = '{sx, sy, sz, ex, ey, ez, COORD_BITS'($urandom), COORD_BITS'($urandom)};
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(CFG_IDX_W'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
		segments_used++;
	endtask

	// offer one point and wait for its beat to be taken
	task automatic offer_point(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
			logic [COORD_BITS-1:0] pz);
		int gap;
		in_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		do @(posedge clk); while (!in_ready);
		sb.note_point(px, py, pz);
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct && gap < 20) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering until every expected beat is back, then let the pipe settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic [COORD_BITS-1:0] pick_coord(int axis);
		longint s, a, k, v;
		case ($urandom_range(9))
			0: return {1'b1, {(COORD_BITS-1){1'b0}}};
			1: return {1'b0, {(COORD_BITS-1){1'b1}}};
			2, 3: return COORD_BITS'($urandom);
			default: begin
				// somewhere along the segment, a little past either end
				s = sb.seg[axis];
				a = longint'(sb.seg[3+axis]) - s;
				k = longint'($urandom_range(24)) - 4;
				v = s + (a * k) / 16 + longint'($urandom_range(512)) - 256;
				return v[COORD_BITS-1:0];
			end
		endcase
	endfunction

	task automatic random_segment(int kind);
		logic [COORD_BITS-1:0] lo, hi, r[6];
		lo = {1'b1, {(COORD_BITS-1){1'b0}}};
		hi = {1'b0, {(COORD_BITS-1){1'b1}}};
		for (int i = 0; i < 6; i++) r[i] = COORD_BITS'($urandom);
		case (kind)
			1: write_segment(lo, lo, lo, hi, hi, hi);
			2: write_segment(COORD_BITS'($urandom_range(8191) - 4096),
				COORD_BITS'($urandom_range(8191) - 4096), COORD_BITS'($urandom_range(8191) - 4096),
				COORD_BITS'($urandom_range(8191) - 4096), COORD_BITS'($urandom_range(8191) - 4096),
				COORD_BITS'($urandom_range(8191) - 4096));
			3: write_segment(r[0], r[1], r[2], r[0], r[1], r[2]);
			4: write_segment(hi, hi, hi, lo, lo, lo);
			default: write_segment(r[0], r[1], r[2], r[3], r[4], r[5]);
		endcase
	endtask

	initial begin
		int tx_pcts[5];
		int rx_pcts[5];
		logic [COORD_BITS-1:0] lo, hi;
		tx_pcts = '{0, 62, 0, 16, 0};
		rx_pcts = '{0, 0, 62, 16, 0};
		lo = {1'b1, {(COORD_BITS-1){1'b0}}};
		hi = {1'b0, {(COORD_BITS-1){1'b1}}};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset segment is a single point at the origin
		offer_point('0, '0, '0);
		offer_point(lo, lo, lo);
		offer_point(hi, hi, hi);
		offer_point(lo, hi, '1);
		wait_drained();

		// directed: segment along x, 10.0 long
		write_segment('0, '0, '0, 24'd2560, '0, '0);
		offer_point('0, '0, '0);
		offer_point(24'd2560, '0, '0);
		offer_point(24'd1280, 24'd256, '0);
		offer_point(-24'sd256, 24'd512, '0);
		offer_point(24'd3000, '0, 24'd100);
		offer_point(24'd1, 24'd1, 24'd1);
		offer_point(24'd853, -24'sd77, 24'd33);
		offer_point(lo, lo, lo);
		offer_point(hi, hi, hi);
		wait_drained();

		// directed: extreme endpoints, overflow-prone points
		write_segment(lo, lo, lo, hi, hi, hi);
		offer_point(lo, lo, lo);
		offer_point(hi, hi, hi);
		offer_point('0, '0, '0);
		offer_point(hi, lo, hi);
		offer_point(lo, hi, lo);
		offer_point('1, '0, '1);
		wait_drained();

		// random phases, each with a new segment and an idle mix taken from a list of five
		for (int ph = 0; ph < 6; ph++) begin
			random_segment(ph);
			tx_idle_pct = tx_pcts[ph % 5];
			rx_stall_pct = rx_pcts[ph % 5];
			if (ph == 4) hold_req = 1'b1;
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				offer_point(pick_coord(0), pick_coord(1), pick_coord(2));
			wait_drained();
		end

		$display("covered %0d beats over %0d segment settings, incl. degenerate and extremes",
			sb.beats_checked, segments_used);
		$display("regions seen: interior %0d, start %0d, end %0d",
			sb.region_hits[0], sb.region_hits[1], sb.region_hits[2]);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/psd_pkg.sv
rtl/core/psd_div.sv
rtl/core/point_segment_distance_squared.sv
rtl/core/psd_check.sv
dv/point_segment_distance_squared_tb.sv
